@@ rtl/core/ecq_pkg.sv @@
// shared types and constants for the erlang-c queue metrics block
package ecq_pkg;

  localparam int MAX_SERVERS = 64;
  localparam int FRAC_BITS   = 16;
  localparam int BW          = FRAC_BITS + 1;   // b, cq and 1.0 in internal format
  localparam int CMW         = 38;              // c*mu, c up to 64, mu 32 bits
  localparam int TW          = 50;              // a*B term of the erlang-b step
  localparam int DW          = 66;              // dividend and quotient width
  localparam int VW          = 51;              // divisor width
  localparam int CNTW        = $clog2(DW + 1);
  localparam int PW          = CMW + BW;        // shared multiplier product width

  localparam logic [BW-1:0] ONE = BW'(1) << FRAC_BITS;

  typedef struct packed {
    logic [31:0] arrival_rate;
    logic [31:0] service_rate;
    logic [6:0]  server_count;
  } in_t;

  typedef struct packed {
    logic        valid_res;
    logic        saturated;
    logic [16:0] wait_probability;
    logic [15:0] utilization;
    logic [31:0] mean_wait;
    logic [31:0] mean_queue_length;
    logic [31:0] mean_sojourn;
  } out_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] dividend;
    logic [VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_CHECK = 12'b0000_0000_0010,
    ST_CMP   = 12'b0000_0000_0100,
    ST_BT    = 12'b0000_0000_1000,
    ST_BB    = 12'b0000_0001_0000,
    ST_X     = 12'b0000_0010_0000,
    ST_CQ    = 12'b0000_0100_0000,
    ST_WQ    = 12'b0000_1000_0000,
    ST_LQ    = 12'b0001_0000_0000,
    ST_INV   = 12'b0010_0000_0000,
    ST_UT    = 12'b0100_0000_0000,
    ST_OUT   = 12'b1000_0000_0000
  } state_t;

endpackage

@@ rtl/core/ecq_div.sv @@
// shared restoring divider, one quotient bit per cycle
module ecq_div (
  input  logic              clk,
  input  logic              rst,
  input  ecq_pkg::div_req_t req,
  output ecq_pkg::div_rsp_t rsp
);

  logic [ecq_pkg::DW-1:0]   acc;
  logic [ecq_pkg::VW-1:0]   rem;
  logic [ecq_pkg::VW-1:0]   dvs;
  logic [ecq_pkg::CNTW-1:0] cnt;
  logic                     busy;
  logic                     done;
  logic [ecq_pkg::VW:0]     trial;
  logic [ecq_pkg::VW:0]     diff;
  logic                     fits;

  assign trial = {rem, acc[ecq_pkg::DW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy <= 1'b1;
        cnt  <= ecq_pkg::CNTW'(ecq_pkg::DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == ecq_pkg::CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in at the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      acc <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      acc <= {acc[ecq_pkg::DW-2:0], fits};
      rem <= fits ? diff[ecq_pkg::VW-1:0] : trial[ecq_pkg::VW-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = acc;

endmodule

@@ rtl/core/ecq_ctrl.sv @@
// sequencer: erlang-b recursion and final metrics on the shared divider and multiplier
module ecq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ecq_pkg::in_t   item,
  output logic           idle,
  output logic           res_valid,
  input  logic           res_ready,
  output ecq_pkg::out_t  res
);

  ecq_pkg::state_t state;

  logic [31:0]              lam;
  logic [31:0]              mu;
  logic [6:0]               c;
  logic [6:0]               k;
  logic [ecq_pkg::CMW-1:0]  cm;
  logic [ecq_pkg::BW-1:0]   b;
  logic [ecq_pkg::TW-1:0]   t;
  logic [31:0]              x;
  logic [ecq_pkg::BW-1:0]   cq;
  logic [32:0]              wq;
  logic [31:0]              lq;
  logic                     lq_sat;
  logic [32:0]              inv;
  logic [15:0]              util;
  logic                     ok;
  logic                     issued;

  logic [ecq_pkg::CMW-1:0]  mul_a;
  logic [ecq_pkg::BW-1:0]   mul_b;
  logic [ecq_pkg::PW-1:0]   prod;
  logic [ecq_pkg::CMW-1:0]  dstab;
  logic [33:0]              soj;
  logic                     is_div;

  ecq_pkg::div_req_t req;
  ecq_pkg::div_rsp_t rsp;

  ecq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign dstab = cm - ecq_pkg::CMW'(lam);
  assign prod  = mul_a * mul_b;

  always_comb begin
    mul_a        = ecq_pkg::CMW'(lam);
    mul_b        = b;
    req.start    = is_div && !issued;
    req.dividend = ecq_pkg::DW'(prod);
    req.divisor  = ecq_pkg::VW'(mu);
    case (state)
      ecq_pkg::ST_CHECK: begin
        mul_a = ecq_pkg::CMW'(mu);
        mul_b = ecq_pkg::BW'(c);
      end
      ecq_pkg::ST_BB: begin
        req.dividend = ecq_pkg::DW'({t, {ecq_pkg::FRAC_BITS{1'b0}}});
        req.divisor  = ecq_pkg::VW'({k, {ecq_pkg::FRAC_BITS{1'b0}}}) + ecq_pkg::VW'(t);
      end
      ecq_pkg::ST_X: mul_b = ecq_pkg::ONE - b;
      ecq_pkg::ST_CQ: begin
        mul_a       = cm;
        req.divisor = ecq_pkg::VW'(cm - ecq_pkg::CMW'(x));
      end
      ecq_pkg::ST_WQ: begin
        req.dividend = ecq_pkg::DW'({cq, {ecq_pkg::FRAC_BITS{1'b0}}});
        req.divisor  = ecq_pkg::VW'(dstab);
      end
      ecq_pkg::ST_LQ: begin
        mul_b       = cq;
        req.divisor = ecq_pkg::VW'(dstab);
      end
      ecq_pkg::ST_INV: req.dividend = {{(ecq_pkg::DW-33){1'b0}}, 1'b1, 32'b0};
      ecq_pkg::ST_UT: begin
        req.dividend = ecq_pkg::DW'({lam, 16'b0});
        req.divisor  = ecq_pkg::VW'(cm);
      end
      default: ;
    endcase
  end

  always_comb begin
    is_div = state inside {ecq_pkg::ST_BT, ecq_pkg::ST_BB, ecq_pkg::ST_CQ, ecq_pkg::ST_WQ,
                           ecq_pkg::ST_LQ, ecq_pkg::ST_INV, ecq_pkg::ST_UT};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ecq_pkg::ST_IDLE;
      issued <= 1'b0;
    end else begin
      if (is_div && !issued) begin
        issued <= 1'b1;
      end else if (rsp.done) begin
        issued <= 1'b0;
      end
      case (state)
        ecq_pkg::ST_IDLE:  if (start) state <= ecq_pkg::ST_CHECK;
        ecq_pkg::ST_CHECK: begin
          if (lam == '0 || mu == '0 || c == '0 || c > 7'(ecq_pkg::MAX_SERVERS)) begin
            state <= ecq_pkg::ST_OUT;
          end else begin
            state <= ecq_pkg::ST_CMP;
          end
        end
        ecq_pkg::ST_CMP:   state <= (ecq_pkg::CMW'(lam) >= cm) ? ecq_pkg::ST_OUT
                                                               : ecq_pkg::ST_BT;
        ecq_pkg::ST_BT:    if (rsp.done) state <= ecq_pkg::ST_BB;
        ecq_pkg::ST_BB:    if (rsp.done) state <= (k == c) ? ecq_pkg::ST_X : ecq_pkg::ST_BT;
        ecq_pkg::ST_X:     state <= ecq_pkg::ST_CQ;
        ecq_pkg::ST_CQ:    if (rsp.done) state <= ecq_pkg::ST_WQ;
        ecq_pkg::ST_WQ:    if (rsp.done) state <= ecq_pkg::ST_LQ;
        ecq_pkg::ST_LQ:    if (rsp.done) state <= ecq_pkg::ST_INV;
        ecq_pkg::ST_INV:   if (rsp.done) state <= ecq_pkg::ST_UT;
        ecq_pkg::ST_UT:    if (rsp.done) state <= ecq_pkg::ST_OUT;
        ecq_pkg::ST_OUT:   if (res_ready) state <= ecq_pkg::ST_IDLE;
        default:           state <= ecq_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ecq_pkg::ST_IDLE: begin
        lam <= item.arrival_rate;
        mu  <= item.service_rate;
        c   <= item.server_count;
        ok  <= 1'b0;
      end
      ecq_pkg::ST_CHECK: cm <= prod[ecq_pkg::CMW-1:0];
      ecq_pkg::ST_CMP: begin
        ok <= ecq_pkg::CMW'(lam) < cm;
        b  <= ecq_pkg::ONE;
        k  <= 7'd1;
      end
      ecq_pkg::ST_BT: if (rsp.done) t <= rsp.quotient[ecq_pkg::TW-1:0];
      ecq_pkg::ST_BB: begin
        if (rsp.done) begin
          b <= rsp.quotient[ecq_pkg::BW-1:0];
          k <= k + 1'b1;
        end
      end
      ecq_pkg::ST_X: x <= 32'(prod >> ecq_pkg::FRAC_BITS);
      ecq_pkg::ST_CQ: begin
        // rounding can push C past one
        if (rsp.done) begin
          cq <= (rsp.quotient > ecq_pkg::DW'(ecq_pkg::ONE)) ? ecq_pkg::ONE
                                                            : rsp.quotient[ecq_pkg::BW-1:0];
        end
      end
      ecq_pkg::ST_WQ: if (rsp.done) wq <= rsp.quotient[32:0];
      ecq_pkg::ST_LQ: begin
        if (rsp.done) begin
          lq_sat <= rsp.quotient > ecq_pkg::DW'(32'hFFFF_FFFF);
          lq     <= (rsp.quotient > ecq_pkg::DW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                  : rsp.quotient[31:0];
        end
      end
      ecq_pkg::ST_INV: if (rsp.done) inv <= rsp.quotient[32:0];
      ecq_pkg::ST_UT:  if (rsp.done) util <= rsp.quotient[15:0];
      default: ;
    endcase
  end

  assign idle      = state == ecq_pkg::ST_IDLE;
  assign res_valid = state == ecq_pkg::ST_OUT;
  assign soj       = 34'(wq) + 34'(inv);

  always_comb begin
    res = '0;
    if (ok) begin
      res.valid_res         = 1'b1;
      res.saturated         = lq_sat || wq[32] || (soj > 34'h0_FFFF_FFFF);
      res.wait_probability  = cq;
      res.utilization       = util;
      res.mean_wait         = wq[32] ? 32'hFFFF_FFFF : wq[31:0];
      res.mean_queue_length = lq;
      res.mean_sojourn      = (soj > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : soj[31:0];
    end
  end

endmodule

@@ rtl/core/erlang_c_queue_metrics.sv @@
// top level: input capture, sequencer and output register
// M/M/c queue metrics from arrival rate, service rate and server count.
// in channel (in_valid/in_ready/in_data) takes one transaction holding lambda and
// mu in Q16.16 and the server count c; out channel (out_valid/out_ready/out_data)
// returns one transaction per input with rho, Erlang-C probability, Wq, Lq and W.
// in_ready is high only while the sequencer is idle; one item at a time is worked.
// each division goes through one shared bit-serial divider, one quotient bit per cycle.
// an invalid item returns without any division, and so does an unstable one.
// the erlang-b recursion runs c steps of two divisions each, then five more
// divisions give C, Wq, Lq, 1/mu and rho.
// the finished result sits in an output register, so a new item is taken while
// the previous result waits; if the receiver stalls with the register full,
// the sequencer holds its next result until the register frees.
// reset (rst, synchronous) empties the output register and idles the sequencer.
module erlang_c_queue_metrics (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ecq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ecq_pkg::out_t out_data
);

  logic          idle;
  logic          res_valid;
  logic          res_ready;
  ecq_pkg::out_t res;

  ecq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && in_ready),
    .item      (in_data),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign in_ready  = idle;
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_data <= res;
  end

endmodule

@@ rtl/core/ecq_checker.sv @@
// port-level checks for the erlang-c queue metrics block
module ecq_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input ecq_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item while busy");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.valid_res |-> !out_data.saturated
      && out_data.wait_probability == '0 && out_data.utilization == '0
      && out_data.mean_wait == '0 && out_data.mean_queue_length == '0
      && out_data.mean_sojourn == '0)
    else $error("invalid result carries nonzero metrics");

  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.wait_probability <= 17'h1_0000)
    else $error("wait probability above one");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind erlang_c_queue_metrics ecq_checker u_ecq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ verif/erlang_c_queue_metrics_tb.sv @@
// testbench for the erlang-c queue metrics block: random and corner items, scoreboard check
module erlang_c_queue_metrics_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 60000;
  localparam int LONG_HOLD  = 3000;
  localparam logic [63:0] Q_ONE = 64'd1 << ecq_pkg::FRAC_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ecq_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ecq_pkg::out_t out_data;

  ecq_pkg::in_t  pending_items[$];
  ecq_pkg::out_t expected_metrics[$];
  int   items_sent = 0;
  int   total_items = 0;
  int   results_seen = 0;
  int   stable_seen = 0;
  int   saturated_seen = 0;
  int   errors = 0;
  int   send_gap = 0;
  int   recv_hold = 0;
  bit   long_hold_done = 1'b0;
  int   idle_cycles = 0;

  erlang_c_queue_metrics dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #2 clk = ~clk;

  // floor(x*y/d), all ones when it does not fit in 64 bits or d is zero
  function automatic logic [63:0] scaled_div(logic [63:0] x, logic [63:0] y, logic [63:0] d);
    logic [127:0] p;
    p = x * y;
    if (d == 0 || p[127:64] >= d) return '1;
    return 64'(p / {64'd0, d});
  endfunction

  function automatic ecq_pkg::out_t queue_metrics(ecq_pkg::in_t item);
    logic [63:0] lam, mu, c, cm, b, t, den, cq, d, wq, lq, inv, soj;
    ecq_pkg::out_t r;
    r   = '0;
    lam = 64'(item.arrival_rate);
    mu  = 64'(item.service_rate);
    c   = 64'(item.server_count);
    if (lam == 0 || mu == 0 || c == 0 || c > 64'(ecq_pkg::MAX_SERVERS)) return r;
    cm = c * mu;
    if (lam >= cm) return r;
    // erlang-b recursion over the servers
    b = Q_ONE;
    for (logic [63:0] k = 1; k <= c; k++) begin
      t = scaled_div(lam, b, mu);
      b = scaled_div(t, Q_ONE, k * Q_ONE + t);
    end
    den = cm - scaled_div(lam, Q_ONE - b, Q_ONE);
    cq  = scaled_div(cm, b, den);
    if (cq > Q_ONE) cq = Q_ONE;
    d   = cm - lam;
    wq  = scaled_div(cq, 64'd1 << 16, d);
    lq  = scaled_div(cq, lam, d);
    inv = (64'd1 << 32) / mu;
    soj = wq + inv;
    r.valid_res = 1'b1;
    r.wait_probability = cq[16:0];
    r.utilization = 16'(scaled_div(lam, 64'd1 << 16, cm));
    if (wq > 64'hFFFF_FFFF) begin r.saturated = 1'b1; wq = 64'hFFFF_FFFF; end
    if (lq > 64'hFFFF_FFFF) begin r.saturated = 1'b1; lq = 64'hFFFF_FFFF; end
    if (soj > 64'hFFFF_FFFF) begin r.saturated = 1'b1; soj = 64'hFFFF_FFFF; end
    r.mean_wait = wq[31:0];
    r.mean_queue_length = lq[31:0];
    r.mean_sojourn = soj[31:0];
    return r;
  endfunction

  // mostly short gaps, some long, and stretches with none at all
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((results_seen / 40) % 3 == 0) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic ecq_pkg::in_t stable_item(int cmax);
    ecq_pkg::in_t it;
    logic [63:0] cm, lam;
    it.server_count = 7'($urandom_range(1, cmax));
    it.service_rate = $urandom >> $urandom_range(0, 31);
    if (it.service_rate < 2) it.service_rate = 2;
    cm  = 64'(it.server_count) * 64'(it.service_rate);
    lam = (cm * $urandom_range(1, 65535)) >> 16;
    if (lam == 0) lam = 1;
    if (lam > 64'hFFFF_FFFF) lam = 64'hFFFF_FFFF;
    it.arrival_rate = lam[31:0];
    return it;
  endfunction

  task automatic add_item(logic [31:0] lam, logic [31:0] mu, logic [6:0] c);
    ecq_pkg::in_t it;
    it.arrival_rate = lam;
    it.service_rate = mu;
    it.server_count = c;
    pending_items.push_back(it);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t mismatch %s: expected %h, actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_metrics.push_back(queue_metrics(in_data));
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and scoreboard
  always @(posedge clk) begin
    ecq_pkg::out_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.valid_res) stable_seen++;
        if (out_data.saturated) saturated_seen++;
        if (expected_metrics.size() == 0) begin
          errors++;
          $display("%0t unexpected transaction: expected none, actual %h", $realtime, out_data);
        end else begin
          exp_r = expected_metrics.pop_front();
          check_field("valid_res", 32'(exp_r.valid_res), 32'(out_data.valid_res));
          check_field("saturated", 32'(exp_r.saturated), 32'(out_data.saturated));
          check_field("wait_probability", 32'(exp_r.wait_probability),
                      32'(out_data.wait_probability));
          check_field("utilization", 32'(exp_r.utilization), 32'(out_data.utilization));
          check_field("mean_wait", exp_r.mean_wait, out_data.mean_wait);
          check_field("mean_queue_length", exp_r.mean_queue_length,
                      out_data.mean_queue_length);
          check_field("mean_sojourn", exp_r.mean_sojourn, out_data.mean_sojourn);
        end
      end
      // one long hold-off so the output register and sequencer both fill
      if (!long_hold_done && items_sent >= 40) begin
        long_hold_done = 1'b1;
        recv_hold = LONG_HOLD;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        recv_hold = pick_gap();
        out_ready <= (recv_hold == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int r;
    // corners: zero fields, too many servers, unstable, saturation, extremes
    add_item(32'd0, 32'h0001_0000, 7'd1);
    add_item(32'h0001_0000, 32'd0, 7'd1);
    add_item(32'h0001_0000, 32'h0002_0000, 7'd0);
    add_item(32'h0001_0000, 32'h0002_0000, 7'd65);
    add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127);
    add_item(32'h0004_0000, 32'h0002_0000, 7'd2);
    add_item(32'h0003_FFFF, 32'h0002_0000, 7'd2);
    add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd1);
    add_item(32'hFFFF_FFFE, 32'hFFFF_FFFF, 7'd1);
    add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd2);
    add_item(32'hFFFF_FFFF, 32'h0400_0000, 7'd64);
    add_item(32'h0000_0001, 32'h0000_0001, 7'd2);
    add_item(32'h0000_0001, 32'h0000_0002, 7'd1);
    add_item(32'h0000_0003, 32'h0000_0001, 7'd4);
    add_item(32'h0000_003F, 32'h0000_0001, 7'd64);
    add_item(32'h0000_0001, 32'hFFFF_FFFF, 7'd1);
    add_item(32'h5555_5555, 32'hAAAA_AAAA, 7'd1);
    add_item(32'h0001_8000, 32'h0001_0000, 7'd2);
    add_item(32'h0010_0000, 32'h0000_4000, 7'd64);
    add_item(32'h7FFF_FFFF, 32'h8000_0000, 7'd1);
    for (int i = 0; i < 250; i++) begin
      r = $urandom_range(0, 99);
      if (r < 65) pending_items.push_back(stable_item(8));
      else if (r < 70) pending_items.push_back(stable_item(64));
      else if (r < 80) add_item($urandom, $urandom, 7'($urandom_range(65, 127)));
      else if (r < 85) add_item($urandom * $urandom_range(0, 1), $urandom * $urandom_range(0, 1),
                                7'($urandom_range(0, 64)));
      else add_item($urandom | 32'h8000_0000, $urandom >> $urandom_range(8, 31),
                    7'($urandom_range(1, 64)));
    end
    total_items = pending_items.size();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (results_seen == total_items);
    repeat (200) @(posedge clk);
    $display("sent %0d items, checked %0d results: %0d stable, %0d saturated", items_sent,
             results_seen, stable_seen, saturated_seen);
    $display("mismatches: %0d", errors);
    if (errors == 0 && expected_metrics.size() == 0 && items_sent == total_items)
      $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
